@@ hw/rtl/dlf_pkg.sv @@
// Package for the delimiter finder: widths, character codes and register indexes.
`default_nettype none

package dlf_pkg;

    localparam int LEVEL_BITS = 8;
    localparam int INDEX_BITS = 16;
    localparam int CHAR_BITS  = 16;
    localparam int POS_BITS   = 16;

    typedef logic [LEVEL_BITS-1:0] level_t;
    typedef logic [INDEX_BITS-1:0] index_t;
    typedef logic [CHAR_BITS-1:0]  char_t;

    localparam char_t CH_DQUOTE    = 16'h0022;
    localparam char_t CH_BACKTICK  = 16'h0060;
    localparam char_t CH_BACKSLASH = 16'h005C;
    localparam char_t CH_PAREN_OPEN   = 16'h0028;
    localparam char_t CH_PAREN_CLOSE  = 16'h0029;
    localparam char_t CH_ANGLE_OPEN   = 16'h003C;
    localparam char_t CH_ANGLE_CLOSE  = 16'h003E;
    localparam char_t CH_SQUARE_OPEN  = 16'h005B;
    localparam char_t CH_SQUARE_CLOSE = 16'h005D;
    localparam char_t CH_CURLY_OPEN   = 16'h007B;
    localparam char_t CH_CURLY_CLOSE  = 16'h007D;

    localparam char_t DELIM_RESET = 16'h002C;

    typedef enum logic {
        CFG_DELIMITER_CHAR   = 1'b0,
        CFG_STOP_AFTER_FIRST = 1'b1
    } cfg_index_t;

    localparam level_t LEVEL_MAX = {LEVEL_BITS{1'b1}};

    function automatic level_t level_up(input level_t v);
        return (v == LEVEL_MAX) ? v : v + level_t'(1);
    endfunction

    function automatic level_t level_down(input level_t v);
        return (v == '0) ? v : v - level_t'(1);
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/top_level_delimiter_finder.sv @@
// Top level of the delimiter finder: escape, quote and bracket tracking per character.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, char_code, end_of_string | into block
//  out     | out_valid, out_ready, position, hit, string_done | out of block
//  cfg     | cfg_we, cfg_index, cfg_data               | into block
//
// One item per cycle sustained while out is not stalled. An item lands in the input
// register, then the per-character update (one compare set and one saturating
// counter step) writes the result register from it once out can take it.
// Items that produce no result still pass through and update the scan state.
// A stall on out holds the result register; the input register fills next,
// then in_ready drops. Reset clears all control and scan state; registers
// return to delimiter ',' and stop mode off.
`default_nettype none

module top_level_delimiter_finder
    import dlf_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [CHAR_BITS-1:0] char_code,
    input  wire logic                 end_of_string,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [POS_BITS-1:0]       position,
    output logic                      hit,
    output logic                      string_done,
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_index,
    input  wire logic [CHAR_BITS-1:0] cfg_data
);

    // configuration
    char_t  delim_reg;
    logic   stop_reg;

    // input register
    logic   s1_valid_reg;
    char_t  s1_char_reg;
    logic   s1_last_reg;

    // scan state
    logic   quoted_reg,   quoted_next;
    logic   named_reg,    named_next;
    logic   odd_bs_reg,   odd_bs_next;
    level_t paren_reg,    paren_next;
    level_t angle_reg,    angle_next;
    level_t square_reg,   square_next;
    level_t curly_reg,    curly_next;
    index_t index_reg,    index_next;
    logic   found_reg,    found_next;

    // result register
    logic                out_valid_reg;
    logic [POS_BITS-1:0] pos_reg;
    logic                hit_reg,  hit_next;
    logic                done_reg;

    logic proc_go;
    logic toggle_q, toggle_n, top_lvl;
    char_t ch;

    assign proc_go  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || proc_go;
    assign ch       = s1_char_reg;

    always_comb
    begin
        odd_bs_next = (ch == CH_BACKSLASH) ? !odd_bs_reg : 1'b0;
        // an escaped quote or backtick is a plain character
        toggle_q = !named_reg && (ch == CH_DQUOTE) && !odd_bs_reg;
        toggle_n = !toggle_q && !quoted_reg && (ch == CH_BACKTICK) && !odd_bs_reg;
        top_lvl  = !toggle_q && !toggle_n && !quoted_reg && !named_reg;

        quoted_next = quoted_reg ^ toggle_q;
        named_next  = named_reg ^ toggle_n;
        paren_next  = paren_reg;
        angle_next  = angle_reg;
        square_next = square_reg;
        curly_next  = curly_reg;

        if (top_lvl)
        begin
            case (ch)
                CH_PAREN_OPEN:   paren_next  = level_up(paren_reg);
                CH_PAREN_CLOSE:  paren_next  = level_down(paren_reg);
                CH_ANGLE_OPEN:   angle_next  = level_up(angle_reg);
                CH_ANGLE_CLOSE:  angle_next  = level_down(angle_reg);
                CH_SQUARE_OPEN:  square_next = level_up(square_reg);
                CH_SQUARE_CLOSE: square_next = level_down(square_reg);
                CH_CURLY_OPEN:   curly_next  = level_up(curly_reg);
                CH_CURLY_CLOSE:  curly_next  = level_down(curly_reg);
                default: ;
            endcase
        end

        // delimiter test sees the depths after this character's update
        hit_next = top_lvl && (ch == delim_reg)
                 && (paren_next == '0) && (angle_next == '0)
                 && (square_next == '0) && (curly_next == '0)
                 && !(stop_reg && found_reg);
        found_next = found_reg || hit_next;
        index_next = index_reg + index_t'(1);

        // string closes: back to a clean scan state
        if (s1_last_reg)
        begin
            quoted_next = 1'b0;
            named_next  = 1'b0;
            odd_bs_next = 1'b0;
            paren_next  = '0;
            angle_next  = '0;
            square_next = '0;
            curly_next  = '0;
            index_next  = '0;
            found_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg     <= DELIM_RESET;
            stop_reg      <= 1'b0;
            s1_valid_reg  <= 1'b0;
            quoted_reg    <= 1'b0;
            named_reg     <= 1'b0;
            odd_bs_reg    <= 1'b0;
            paren_reg     <= '0;
            angle_reg     <= '0;
            square_reg    <= '0;
            curly_reg     <= '0;
            index_reg     <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_DELIMITER_CHAR:   delim_reg <= cfg_data;
                    CFG_STOP_AFTER_FIRST: stop_reg  <= cfg_data[0];
                    default: ;
                endcase
            end

            if (in_ready)
                s1_valid_reg <= in_valid;

            if (proc_go)
            begin
                quoted_reg    <= quoted_next;
                named_reg     <= named_next;
                odd_bs_reg    <= odd_bs_next;
                paren_reg     <= paren_next;
                angle_reg     <= angle_next;
                square_reg    <= square_next;
                curly_reg     <= curly_next;
                index_reg     <= index_next;
                found_reg     <= found_next;
                out_valid_reg <= hit_next || s1_last_reg;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_char_reg <= char_code;
            s1_last_reg <= end_of_string;
        end
        if (proc_go)
        begin
            pos_reg  <= POS_BITS'(index_reg);
            hit_reg  <= hit_next;
            done_reg <= s1_last_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign position    = pos_reg;
    assign hit         = hit_reg;
    assign string_done = done_reg;

endmodule

`default_nettype wire

@@ hw/rtl/dlf_checker.sv @@
// Port-level checker for the delimiter finder, bound to the top level.
`default_nettype none

module dlf_checker
    import dlf_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_ready,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire logic [POS_BITS-1:0] position,
    input wire logic                hit,
    input wire logic                string_done
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(position)
            && $stable(hit) && $stable(string_done))
        else $error("result changed while stalled");

    // a result always carries a hit or an end marker
    a_out_meaning: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> hit || string_done)
        else $error("result with neither hit nor end marker");

    // nothing leaves the block while reset is held
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");

    // only one item fits behind a stalled result
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready && in_valid && in_ready |=> out_ready || !in_ready)
        else $error("input taken past a full pipeline");

endmodule

bind top_level_delimiter_finder dlf_checker u_dlf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .position    (position),
    .hit         (hit),
    .string_done (string_done)
);

`default_nettype wire
